/* hw/rtl/fpll_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed pool linked list package
// Request and status codes, controller states and default pool size.
// ----------------------------------------------------------------------------
package fpll_pkg;

  localparam int unsigned EntriesDef = 16;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_FULL    = 2'd1,
    STS_MISS    = 2'd2,
    STS_NO_NEXT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LINK,
    ST_PRED,
    ST_DEL_FIX,
    ST_FREE_SCAN,
    ST_APP_SLOT,
    ST_APP_TAIL,
    ST_RESP
  } state_e;

endpackage

/* hw/rtl/fpll_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fpll_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/fixed_pool_linked_list_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed pool linked list
// Singly linked list over a pool of Entries slots: append, delete, successor.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_* valid/ready channel (req_type_i, value_i,
//   position_i); each request gives exactly one response on the out_*
//   valid/ready channel (status_o, node_index_o, list_size_o).
//   Requests are handled one at a time. An append runs a free slot scan
//   over the in-use bits, one slot a cycle; a delete of an entry that is
//   not the head runs a predecessor scan that reads one link from the
//   link RAM per cycle, pipelined behind its registered read. The next
//   request is taken in the cycle after the response is loaded.
//   Links live in a RAM with one write and one read port; in-use bits, head,
//   tail and count sit in flip-flops and are cleared by reset, so the list is
//   empty straight after reset with no clearing pass.
//   The response sits in an output register: in_ready_o returns once the
//   response is loaded, even while the receiver stalls. A following response
//   waits in its final state until the output register is taken.
// ----------------------------------------------------------------------------
module fixed_pool_linked_list_top #(
  parameter int unsigned Entries = fpll_pkg::EntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [3:0]         node_index_o,
  output logic [4:0]         list_size_o
);

  import fpll_pkg::*;

  localparam int unsigned IdxW  = $clog2(Entries);
  localparam int unsigned CntW  = $clog2(Entries + 1);
  localparam int unsigned LinkW = IdxW + 1;

  state_e state_q, state_d;

  logic [1:0]        req_q;
  logic [31:0]       value_q;
  logic [3:0]        pos_q;
  logic [Entries-1:0] used_q, used_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [IdxW-1:0]   tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic [IdxW-1:0]   chk_q, chk_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]   pred_q, pred_d;
  logic [IdxW-1:0]   slot_q, slot_d;
  logic [LinkW-1:0]  pos_link_q, pos_link_d;
  status_e           res_sts_q, res_sts_d;
  logic [IdxW-1:0]   res_idx_q, res_idx_d;

  logic              out_valid_q;
  logic [1:0]        out_sts_q;
  logic [3:0]        out_idx_q;
  logic [4:0]        out_size_q;

  logic              link_we;
  logic [IdxW-1:0]   link_waddr;
  logic [LinkW-1:0]  link_wdata;
  logic [IdxW-1:0]   link_raddr;
  logic [LinkW-1:0]  link_rdata;
  logic              val_we;

  logic [IdxW-1:0]   pidx;
  logic              in_range;
  logic              pos_used;
  logic              is_full;
  logic              is_empty;
  logic              lnk_none;
  logic [IdxW-1:0]   lnk_idx;
  logic              chk_hit;
  logic              chk_last;
  logic              slot_free;
  logic              out_free;
  logic              out_load;
  logic              accept;

  // Link RAM: bit IdxW is the "no successor" flag.
  fpll_ram #(
    .Width(LinkW),
    .Depth(Entries)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  // Value store: written by appends, never read back by any request.
  fpll_ram #(
    .Width(32),
    .Depth(Entries)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(slot_q),
    .wdata_i(value_q),
    .raddr_i(slot_q),
    .rdata_o()
  );

  assign accept    = in_valid_i && in_ready_o;
  assign pidx      = IdxW'(pos_q);
  assign in_range  = 32'(pos_q) < 32'(Entries);
  assign pos_used  = in_range && used_q[pidx];
  assign is_full   = count_q == CntW'(Entries);
  assign is_empty  = count_q == '0;
  assign lnk_none  = link_rdata[IdxW];
  assign lnk_idx   = link_rdata[IdxW-1:0];
  assign chk_hit   = chk_vld_q && used_q[chk_q] && !lnk_none && (lnk_idx == pidx);
  assign chk_last  = chk_q == IdxW'(Entries - 1);
  assign slot_free = !used_q[scan_q];
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = (state_q == ST_RESP) && out_free;
  assign link_raddr = (state_q == ST_PRED) ? scan_q : pidx;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (req_e'(req_q))
          REQ_APPEND: state_d = is_full ? ST_RESP : ST_FREE_SCAN;
          REQ_DELETE: state_d = (is_empty || !pos_used) ? ST_RESP : ST_LINK;
          REQ_QUERY:  state_d = pos_used ? ST_LINK : ST_RESP;
          default:    state_d = ST_RESP;
        endcase
      end
      ST_LINK: begin
        if (req_e'(req_q) == REQ_QUERY || head_q == pidx) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_PRED;
        end
      end
      ST_PRED: begin
        if (chk_hit) begin
          state_d = ST_DEL_FIX;
        end else if (chk_vld_q && chk_last) begin
          state_d = ST_RESP;
        end
      end
      ST_DEL_FIX:   state_d = ST_RESP;
      ST_FREE_SCAN: begin
        if (slot_free) state_d = ST_APP_SLOT;
      end
      ST_APP_SLOT:  state_d = is_empty ? ST_RESP : ST_APP_TAIL;
      ST_APP_TAIL:  state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    used_d     = used_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    scan_d     = scan_q;
    chk_d      = chk_q;
    chk_vld_d  = chk_vld_q;
    pred_d     = pred_q;
    slot_d     = slot_q;
    pos_link_d = pos_link_q;
    res_sts_d  = res_sts_q;
    res_idx_d  = res_idx_q;
    link_we    = 1'b0;
    link_waddr = slot_q;
    link_wdata = {1'b1, {IdxW{1'b0}}};
    val_we     = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_DECODE: begin
        res_sts_d = STS_MISS;
        res_idx_d = '0;
        scan_d    = '0;
        chk_vld_d = 1'b0;
        if (req_e'(req_q) == REQ_APPEND && is_full) res_sts_d = STS_FULL;
      end
      ST_LINK: begin
        pos_link_d = link_rdata;
        if (req_e'(req_q) == REQ_QUERY) begin
          if (lnk_none || !used_q[lnk_idx]) begin
            res_sts_d = STS_NO_NEXT;
          end else begin
            res_sts_d = STS_DONE;
            res_idx_d = lnk_idx;
          end
        end else if (head_q == pidx) begin
          if (count_q > CntW'(1) && !lnk_none) head_d = lnk_idx;
          used_d[pidx] = 1'b0;
          count_d      = count_q - CntW'(1);
          res_sts_d    = STS_DONE;
        end
      end
      ST_PRED: begin
        // Issue the next read while checking the link returned for chk_q.
        scan_d    = (scan_q == IdxW'(Entries - 1)) ? '0 : scan_q + IdxW'(1);
        chk_d     = scan_q;
        chk_vld_d = 1'b1;
        if (chk_hit) begin
          pred_d = chk_q;
        end else if (chk_vld_q && chk_last) begin
          used_d[pidx] = 1'b0;
          count_d      = count_q - CntW'(1);
          res_sts_d    = STS_DONE;
        end
      end
      ST_DEL_FIX: begin
        link_we    = 1'b1;
        link_waddr = pred_q;
        link_wdata = pos_link_q;
        if (tail_q == pidx) tail_d = pred_q;
        used_d[pidx] = 1'b0;
        count_d      = count_q - CntW'(1);
        res_sts_d    = STS_DONE;
      end
      ST_FREE_SCAN: begin
        if (slot_free) begin
          slot_d = scan_q;
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end
      ST_APP_SLOT: begin
        link_we      = 1'b1;
        val_we       = 1'b1;
        used_d[slot_q] = 1'b1;
        res_sts_d    = STS_DONE;
        res_idx_d    = slot_q;
        if (is_empty) begin
          head_d  = slot_q;
          tail_d  = slot_q;
          count_d = count_q + CntW'(1);
        end
      end
      ST_APP_TAIL: begin
        link_we    = 1'b1;
        link_waddr = tail_q;
        link_wdata = {1'b0, slot_q};
        tail_d     = slot_q;
        count_d    = count_q + CntW'(1);
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      chk_vld_q <= chk_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    scan_q     <= scan_d;
    chk_q      <= chk_d;
    pred_q     <= pred_d;
    slot_q     <= slot_d;
    pos_link_q <= pos_link_d;
    res_sts_q  <= res_sts_d;
    res_idx_q  <= res_idx_d;
    if (out_load) begin
      out_sts_q  <= res_sts_q;
      out_idx_q  <= 4'(res_idx_q);
      out_size_q <= 5'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_sts_q;
  assign node_index_o = out_idx_q;
  assign list_size_o  = out_size_q;

endmodule

/* sim/list_response_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list response checker
// Watches both channels of the list block, keeps a shadow copy of the pool
// (links, in-use marks, head, tail, count), predicts each response and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module list_response_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] req_type_i,
  input  logic [3:0] position_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] status_i,
  input  logic [3:0] node_index_i,
  input  logic [4:0] list_size_i,
  output int         fail_count_o,
  output int         pending_o
);

  import fpll_pkg::*;

  localparam int Slots = EntriesDef;

  typedef struct packed {
    status_e    status;
    logic [3:0] node;
    logic [4:0] size;
  } list_resp_t;

  logic [3:0] next_of [Slots];
  logic       no_next [Slots];
  logic       in_use  [Slots];
  logic [3:0] head_ptr;
  logic [3:0] tail_ptr;
  logic [4:0] used_cnt;

  list_resp_t awaited_resp_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Update the shadow pool for one request and return the response it gives.
  function automatic list_resp_t apply_request(logic [1:0] req, logic [3:0] pos);
    list_resp_t r;
    int         slot;
    int         pred;
    r.status = STS_MISS;
    r.node   = '0;
    case (req)
      REQ_APPEND: begin
        slot = -1;
        for (int i = Slots - 1; i >= 0; i--) begin
          if (!in_use[i]) slot = i;
        end
        if (used_cnt >= Slots || slot < 0) begin
          r.status = STS_FULL;
        end else begin
          in_use[slot]  = 1'b1;
          no_next[slot] = 1'b1;
          next_of[slot] = '0;
          if (used_cnt == 0) begin
            head_ptr = 4'(slot);
          end else begin
            next_of[tail_ptr] = 4'(slot);
            no_next[tail_ptr] = 1'b0;
          end
          tail_ptr = 4'(slot);
          used_cnt = used_cnt + 1;
          r.status = STS_DONE;
          r.node   = 4'(slot);
        end
      end
      REQ_DELETE: begin
        if (used_cnt != 0 && in_use[pos]) begin
          if (head_ptr == pos) begin
            if (used_cnt > 1 && !no_next[pos]) head_ptr = next_of[pos];
          end else begin
            pred = -1;
            for (int i = Slots - 1; i >= 0; i--) begin
              if (in_use[i] && !no_next[i] && next_of[i] == pos) pred = i;
            end
            // Predecessor takes over the link; with none found just free it
            if (pred >= 0) begin
              next_of[pred] = next_of[pos];
              no_next[pred] = no_next[pos];
              if (tail_ptr == pos) tail_ptr = 4'(pred);
            end
          end
          in_use[pos]  = 1'b0;
          no_next[pos] = 1'b1;
          next_of[pos] = '0;
          used_cnt     = used_cnt - 1;
          r.status     = STS_DONE;
        end
      end
      REQ_QUERY: begin
        if (in_use[pos]) begin
          if (no_next[pos] || !in_use[next_of[pos]]) begin
            r.status = STS_NO_NEXT;
          end else begin
            r.status = STS_DONE;
            r.node   = next_of[pos];
          end
        end
      end
      default: ;
    endcase
    r.size = used_cnt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_resp_t got;
    list_resp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        next_of[i] = '0;
        no_next[i] = 1'b1;
        in_use[i]  = 1'b0;
      end
      head_ptr = '0;
      tail_ptr = '0;
      used_cnt = '0;
      awaited_resp_q.delete();
      pending_o = 0;
    end else begin
      // Check the outgoing transfer first: it can never belong to a request
      // taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        got.status = status_e'(status_i);
        got.node   = node_index_i;
        got.size   = list_size_i;
        if (awaited_resp_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: response with none awaited: status %0d node %0d size %0d",
                     $time, got.status, got.node, got.size);
          end
          fail_count_o++;
        end else begin
          want = awaited_resp_q.pop_front();
          if (got != want) begin
            if (fail_count_o < 10) begin
              $display("%0t: expected status %0d node %0d size %0d, got %0d %0d %0d",
                       $time, want.status, want.node, want.size,
                       got.status, got.node, got.size);
            end
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_resp_q.push_back(apply_request(req_type_i, position_i));
      end
      pending_o = awaited_resp_q.size();
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed pool linked list testbench
// Directed appends, deletes and successor queries on empty, full and partly
// filled lists, then random request mixes that swing the list between empty
// and full, with random idling on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
  import fpll_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int          LongHold    = 80;
  localparam int          RandomItems = 920;
  localparam int          QuietTail   = 150;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic signed [31:0] value_i;
  logic [3:0]         position_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic [3:0]         node_index_o;
  logic [4:0]         list_size_o;

  int          fail_count;
  int          pending;
  bit          tx_gaps       = 1'b1;
  bit          rx_gaps       = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned cycle_cnt     = 0;

  always #5 clk_i = ~clk_i;

  fixed_pool_linked_list_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .node_index_o(node_index_o),
    .list_size_o (list_size_o)
  );

  list_response_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status_o),
    .node_index_i(node_index_o),
    .list_size_i (list_size_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int rx_idle;
    rx_idle     = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_idle       = LongHold;
      end
      if (rx_idle == 0 && rx_gaps && $urandom_range(0, 4) == 0) begin
        rx_idle = $urandom_range(1, 4);
      end
      if (rx_idle > 0) begin
        out_ready_i <= 1'b0;
        rx_idle--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until the transfer; called at a falling edge
  task automatic send_req(req_e req, logic [31:0] val, logic [3:0] pos);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_responses();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_random(int append_pct);
    int          pick;
    logic [31:0] val;
    case ($urandom_range(0, 7))
      0:       val = 32'h7FFF_FFFF;
      1:       val = 32'h8000_0000;
      default: val = $urandom;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < append_pct) begin
      send_req(REQ_APPEND, val, 4'($urandom));
    end else if (pick < append_pct + (100 - append_pct) / 2) begin
      send_req(REQ_DELETE, val, 4'($urandom_range(0, 15)));
    end else begin
      send_req(REQ_QUERY, val, 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    int append_pct;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_APPEND;
    value_i    = '0;
    position_i = '0;
    append_pct = 50;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty list: query and delete both miss
    send_req(REQ_QUERY, 32'd0, 4'd0);
    send_req(REQ_DELETE, 32'd0, 4'd0);
    // Fill the pool, extreme values first, then one append too many
    send_req(REQ_APPEND, 32'h7FFF_FFFF, 4'd0);
    send_req(REQ_APPEND, 32'h8000_0000, 4'd15);
    send_req(REQ_APPEND, 32'h0000_0000, 4'd0);
    send_req(REQ_APPEND, 32'hFFFF_FFFF, 4'd15);
    for (int i = 4; i < EntriesDef; i++) send_req(REQ_APPEND, $urandom, 4'($urandom));
    send_req(REQ_APPEND, 32'h1234_5678, 4'd0);
    // Tail has no successor; then drop tail, head and a middle entry
    send_req(REQ_QUERY, 32'd0, 4'd15);
    send_req(REQ_DELETE, 32'd0, 4'd15);
    send_req(REQ_DELETE, 32'd0, 4'd0);
    send_req(REQ_DELETE, 32'd0, 4'd5);
    send_req(REQ_QUERY, 32'd0, 4'd4);
    send_req(REQ_QUERY, 32'd0, 4'd5);
    send_req(REQ_DELETE, 32'd0, 4'd5);
    // Lowest free entry is reused and linked after the tail
    send_req(REQ_APPEND, 32'h5A5A_A5A5, 4'd0);
    send_req(REQ_QUERY, 32'd0, 4'd14);
    drain_responses();

    for (int i = 0; i < RandomItems; i++) begin
      // Alternate filling and emptying phases so both ends are reached
      if (i % 80 == 0) begin
        append_pct = ((i / 80) % 2 == 0) ? $urandom_range(55, 85) : $urandom_range(10, 40);
      end
      if (i == 300) long_hold_req = 1'b1;
      if (i == 600) drain_responses();
      if (i == RandomItems - QuietTail) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      send_random(append_pct);
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* fixed_pool_linked_list_top.f */
hw/rtl/fpll_pkg.sv
hw/rtl/fpll_ram.sv
hw/rtl/fixed_pool_linked_list_top.sv
sim/list_response_check.sv
sim/testbench.sv
